// ===== rtl/core/vwf_pkg.sv =====
// Shared constants and register codes for the v2 wall-function value block.
package vwf_pkg;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CMU_ROOT4 = 2'd0,
		CFG_KAPPA     = 2'd1,
		CFG_YPLUS_LAM = 2'd2
	} cfg_idx_t;

	// Register reset values, unsigned Q8.24
	localparam logic [31:0] CMU_ROOT4_RST = 32'd9189265;
	localparam logic [31:0] KAPPA_RST     = 32'd6878659;
	localparam logic [31:0] YPLUS_LAM_RST = 32'd193441300;

	// Model coefficients, Q.32
	localparam logic [63:0] K_C193 = 64'd828928688;   // 0.193
	localparam logic [63:0] K_B94  = 64'd4037269258;  // 0.94
	localparam logic [63:0] K_LN2  = 64'd2977044472;  // ln 2

	// Dividend for 0.193/kappa with 32 fraction bits
	localparam logic [63:0] RATIO_NUM = K_C193 << 24;

endpackage

// ===== rtl/core/vwf_mul.sv =====
// Two-stage 64x64 multiplier built from four 32x32 partial products, with tag.
module vwf_mul #(
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [63:0]      a,
	input  logic [63:0]      b,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_v,
	output logic [127:0]     p,
	output logic [TAG_W-1:0] out_tag
);

	logic [63:0]      pp_s1 [4];
	logic [TAG_W-1:0] tag_s1;
	logic             v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			v_s1  <= in_v;
			out_v <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s1[0] <= 64'(a[31:0])  * 64'(b[31:0]);
			pp_s1[1] <= 64'(a[31:0])  * 64'(b[63:32]);
			pp_s1[2] <= 64'(a[63:32]) * 64'(b[31:0]);
			pp_s1[3] <= 64'(a[63:32]) * 64'(b[63:32]);
			tag_s1   <= in_tag;
			p        <= {64'b0, pp_s1[0]} + ({64'b0, pp_s1[1]} << 32)
				+ ({64'b0, pp_s1[2]} << 32) + ({pp_s1[3], 64'b0});
			out_tag  <= tag_s1;
		end
	end

endmodule

// ===== rtl/core/vwf_sqrt.sv =====
// Pipelined integer square root of a 128-bit radicand, one root bit per stage.
module vwf_sqrt #(
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [127:0]     x,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_v,
	output logic [63:0]      root,
	output logic [TAG_W-1:0] out_tag
);

	logic [127:0]     x_s    [65];
	logic [65:0]      rem_s  [65];
	logic [63:0]      root_s [65];
	logic [TAG_W-1:0] tag_s  [65];
	logic             v_s    [65];

	assign x_s[0]    = x;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign tag_s[0]  = in_tag;
	assign v_s[0]    = in_v;

	for (genvar j = 0; j < 64; j++) begin : g_stage
		logic [67:0] rem2;
		logic [67:0] trial;
		logic        ge;

		always_comb begin
			rem2  = {rem_s[j], x_s[j][127:126]};
			trial = {2'b00, root_s[j], 2'b01};
			ge    = rem2 >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? 66'(rem2 - trial) : 66'(rem2);
				root_s[j+1] <= {root_s[j][62:0], ge};
				x_s[j+1]    <= x_s[j] << 2;
				tag_s[j+1]  <= tag_s[j];
			end
		end
	end

	assign out_v   = v_s[64];
	assign root    = root_s[64];
	assign out_tag = tag_s[64];

endmodule

// ===== rtl/core/vwf_div.sv =====
// Pipelined restoring divider, 128-bit dividend by 64-bit divisor, one quotient bit per stage.
module vwf_div #(
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [127:0]     n,
	input  logic [63:0]      d,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_v,
	output logic [63:0]      q,
	output logic [TAG_W-1:0] out_tag
);

	logic [63:0]      rem_s [65];
	logic [63:0]      lo_s  [65];
	logic [63:0]      q_s   [65];
	logic [63:0]      d_s   [65];
	logic [TAG_W-1:0] tag_s [65];
	logic             v_s   [65];

	assign rem_s[0] = n[127:64];
	assign lo_s[0]  = n[63:0];
	assign q_s[0]   = '0;
	assign d_s[0]   = d;
	assign tag_s[0] = in_tag;
	assign v_s[0]   = in_v;

	for (genvar j = 0; j < 64; j++) begin : g_stage
		logic [64:0] r65;
		logic        ge;

		always_comb begin
			r65 = {rem_s[j], lo_s[j][63]};
			ge  = r65 >= {1'b0, d_s[j]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? 64'(r65 - {1'b0, d_s[j]}) : r65[63:0];
				lo_s[j+1]  <= lo_s[j] << 1;
				q_s[j+1]   <= {q_s[j][62:0], ge};
				d_s[j+1]   <= d_s[j];
				tag_s[j+1] <= tag_s[j];
			end
		end
	end

	assign out_v   = v_s[64];
	assign q       = q_s[64];
	assign out_tag = tag_s[64];

endmodule

// ===== rtl/core/vwf_log2.sv =====
// Pipelined log2: normalising shift over six stages, then 32 squaring steps.
module vwf_log2 #(
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [63:0]      x,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_v,
	output logic [5:0]       msb,
	output logic [31:0]      frac,
	output logic [TAG_W-1:0] out_tag
);

	localparam int ST_W = TAG_W + 6;

	logic [63:0]      n_s   [7];
	logic [5:0]       lz_s  [7];
	logic [TAG_W-1:0] tag_s [7];
	logic             v_s   [7];

	// zero is treated as one lsb
	assign n_s[0]   = (x == '0) ? 64'd1 : x;
	assign lz_s[0]  = '0;
	assign tag_s[0] = in_tag;
	assign v_s[0]   = in_v;

	for (genvar s = 0; s < 6; s++) begin : g_norm
		localparam int SH = 32 >> s;
		logic top_zero;

		assign top_zero = (n_s[s] >> (64 - SH)) == '0;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[s+1] <= 1'b0;
			end else if (en) begin
				v_s[s+1] <= v_s[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[s+1]   <= top_zero ? (n_s[s] << SH) : n_s[s];
				lz_s[s+1]  <= top_zero ? 6'(lz_s[s] + 6'(SH)) : lz_s[s];
				tag_s[s+1] <= tag_s[s];
			end
		end
	end

	logic [63:0]     m_w  [33];
	logic [31:0]     fr_w [33];
	logic [ST_W-1:0] st_w [33];
	logic            sv_w [33];

	assign m_w[0]  = n_s[6];
	assign fr_w[0] = '0;
	assign st_w[0] = {6'(6'd63 - lz_s[6]), tag_s[6]};
	assign sv_w[0] = v_s[6];

	for (genvar i = 0; i < 32; i++) begin : g_sq
		logic [127:0]       sq;
		logic [ST_W+31:0]   otag;
		logic               hi;

		vwf_mul #(.TAG_W(ST_W + 32)) u_mul (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_v    (sv_w[i]),
			.a       (m_w[i]),
			.b       (m_w[i]),
			.in_tag  ({fr_w[i], st_w[i]}),
			.out_v   (sv_w[i+1]),
			.p       (sq),
			.out_tag (otag)
		);

		assign hi        = sq[127];
		assign m_w[i+1]  = hi ? sq[127:64] : sq[126:63];
		assign fr_w[i+1] = {otag[ST_W+30:ST_W], hi};
		assign st_w[i+1] = otag[ST_W-1:0];
	end

	assign out_v   = sv_w[32];
	assign frac    = fr_w[32];
	assign msb     = st_w[32][ST_W-1:TAG_W];
	assign out_tag = st_w[32][TAG_W-1:0];

endmodule

// ===== rtl/core/v2_wall_function_value_top.sv =====
// Top level of the v2 wall-function boundary value pipeline.
//
// One wall face per item: from wall distance, viscosity, density and turbulent
// kinetic energy (unsigned, FRAC_BITS fraction bits) the block forms uTau and
// yPlus and returns the v2 wall value, log law above the crossover yPlus and
// laminar form below it, signed and saturated, with a flag when it clamps.
// An item is taken every cycle while the result side keeps up; the pipeline
// depth is set mostly by the 64-stage square root, the 64-stage yPlus
// divider and the 32 squaring steps of the log2 unit, each squaring a
// two-stage multiplier. A stall holds every stage in place.
// After reset and after each write of kappa a serial divider forms
// 0.193/kappa; an item only needs it far down the pipe, after the divider
// is done, so no item is held back for it.
module v2_wall_function_value_top #(
	parameter int DATA_WIDTH = 64,
	parameter int FRAC_BITS  = 40
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_we,
	input  logic [vwf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                 cfg_data,
	// input items
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [63:0]                 wall_distance,
	input  logic [63:0]                 viscosity,
	input  logic [63:0]                 density,
	input  logic [63:0]                 turb_energy,
	// result items
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [63:0]          v2_value,
	output logic                        saturated
);

	import vwf_pkg::*;

	localparam logic [63:0] DMASK = {64{1'b1}} >> (64 - DATA_WIDTH);
	localparam logic [63:0] MAXP  = DMASK >> 1;
	localparam logic [63:0] MINN  = ~MAXP;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [31:0] cmu_root4_q, kappa_q, yplus_lam_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmu_root4_q <= CMU_ROOT4_RST;
			kappa_q     <= KAPPA_RST;
			yplus_lam_q <= YPLUS_LAM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CMU_ROOT4: cmu_root4_q <= cfg_data;
				CFG_KAPPA:     kappa_q     <= cfg_data;
				CFG_YPLUS_LAM: yplus_lam_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// 0.193/kappa, one quotient bit a cycle; zero kappa acts as one lsb
	// ---------------------------------------------------------------
	logic [6:0]  rcnt_q;
	logic [31:0] rr_q;
	logic [63:0] ratio_q;
	logic [31:0] kd;
	logic [32:0] r33;
	logic        rge;

	always_comb begin
		kd  = (kappa_q == '0) ? 32'd1 : kappa_q;
		r33 = {rr_q, RATIO_NUM[6'(rcnt_q - 7'd1)]};
		rge = r33 >= {1'b0, kd};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q  <= 7'd64;
			rr_q    <= '0;
			ratio_q <= '0;
		end else if (cfg_we && cfg_index == CFG_KAPPA) begin
			rcnt_q  <= 7'd64;
			rr_q    <= '0;
			ratio_q <= '0;
		end else if (rcnt_q != '0) begin
			rr_q    <= rge ? 32'(r33 - {1'b0, kd}) : r33[31:0];
			ratio_q <= {ratio_q[62:0], rge};
			rcnt_q  <= rcnt_q - 7'd1;
		end
	end

	// ---------------------------------------------------------------
	// Pipeline advance: every stage moves unless the output holds a result
	// that is not being taken
	// ---------------------------------------------------------------
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic [63:0] y_in, mu_in, rho_in, k_in;
	assign y_in   = wall_distance & DMASK;
	assign mu_in  = viscosity & DMASK;
	assign rho_in = density & DMASK;
	assign k_in   = turb_energy & DMASK;

	// sqrt(k) with the radicand scaled so the root keeps FRAC_BITS
	logic         v1;
	logic [63:0]  sqrtk1;
	logic [191:0] tag1;

	vwf_sqrt #(.TAG_W(192)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(in_valid),
		.x({64'b0, k_in} << FRAC_BITS),
		.in_tag({y_in, mu_in, rho_in}),
		.out_v(v1), .root(sqrtk1), .out_tag(tag1)
	);

	// uTau = cmu_root4 * sqrt(k), Q8.24 scaling removed
	logic         v2;
	logic [127:0] p2;
	logic [191:0] tag2;
	logic [63:0]  utau2, y2f, mu2, rho2;

	vwf_mul #(.TAG_W(192)) u_mul_utau (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v1),
		.a({32'b0, cmu_root4_q}), .b(sqrtk1), .in_tag(tag1),
		.out_v(v2), .p(p2), .out_tag(tag2)
	);

	assign utau2 = p2[87:24];
	assign {y2f, mu2, rho2} = tag2;

	// t = uTau * y
	logic         v3;
	logic [127:0] p3;
	logic [191:0] tag3;
	logic [63:0]  utau3, mu3, rho3, t3;
	logic         tov3;

	vwf_mul #(.TAG_W(192)) u_mul_t (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v2),
		.a(utau2), .b(y2f), .in_tag({utau2, mu2, rho2}),
		.out_v(v3), .p(p3), .out_tag(tag3)
	);

	assign {utau3, mu3, rho3} = tag3;
	assign t3   = p3[FRAC_BITS +: 64];
	assign tov3 = (p3 >> (64 + FRAC_BITS)) != '0;

	// n = t * rho; zero viscosity also lands in the overflow test
	logic         v4;
	logic [127:0] p4;
	logic [128:0] tag4;
	logic [63:0]  utau4, mu4;
	logic         tov4, ovf4;

	vwf_mul #(.TAG_W(129)) u_mul_n (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v3),
		.a(t3), .b(rho3), .in_tag({utau3, mu3, tov3}),
		.out_v(v4), .p(p4), .out_tag(tag4)
	);

	assign {utau4, mu4, tov4} = tag4;
	assign ovf4 = tov4 || (p4[127:64] >= mu4);

	// yPlus = n / mu
	logic        v5;
	logic [63:0] yp5;
	logic [64:0] tag5;
	logic [63:0] utau5;
	logic        ovf5;

	vwf_div #(.TAG_W(65)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v4),
		.n(p4), .d(mu4), .in_tag({utau4, ovf4}),
		.out_v(v5), .q(yp5), .out_tag(tag5)
	);

	assign {utau5, ovf5} = tag5;

	// uTau squared and the branch decision
	logic         v6;
	logic [127:0] p6;
	logic [64:0]  tag6;
	logic [63:0]  yp6, u26;
	logic         ovf6, u2ov6, islog6;

	vwf_mul #(.TAG_W(65)) u_mul_u2 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v5),
		.a(utau5), .b(utau5), .in_tag({yp5, ovf5}),
		.out_v(v6), .p(p6), .out_tag(tag6)
	);

	assign {yp6, ovf6} = tag6;
	assign u26    = p6[FRAC_BITS +: 64];
	assign u2ov6  = (p6 >> (64 + FRAC_BITS)) != '0;
	assign islog6 = ({64'b0, yp6} << 24) > ({96'b0, yplus_lam_q} << FRAC_BITS);

	// Laminar branch: yPlus^2
	logic         v7;
	logic [127:0] p7;
	logic [130:0] tag7;
	logic [63:0]  yp7, u27, y2v7;
	logic         u2ov7, ovf7, islog7, lov7;

	vwf_mul #(.TAG_W(131)) u_mul_y2 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v6),
		.a(yp6), .b(yp6), .in_tag({yp6, u26, u2ov6, ovf6, islog6}),
		.out_v(v7), .p(p7), .out_tag(tag7)
	);

	assign {yp7, u27, u2ov7, ovf7, islog7} = tag7;
	assign y2v7 = p7[FRAC_BITS +: 64];
	assign lov7 = (p7 >> (64 + FRAC_BITS)) != '0;

	// yPlus^4
	logic         v8;
	logic [127:0] p8;
	logic [131:0] tag8;
	logic [63:0]  yp8, u28, y4v8;
	logic         u2ov8, ovf8, islog8, lov8a, lov8;

	vwf_mul #(.TAG_W(132)) u_mul_y4 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v7),
		.a(y2v7), .b(y2v7), .in_tag({yp7, u27, u2ov7, ovf7, islog7, lov7}),
		.out_v(v8), .p(p8), .out_tag(tag8)
	);

	assign {yp8, u28, u2ov8, ovf8, islog8, lov8a} = tag8;
	assign y4v8 = p8[FRAC_BITS +: 64];
	assign lov8 = lov8a || ((p8 >> (64 + FRAC_BITS)) != '0);

	// 0.193 * yPlus^4
	logic         v9;
	logic [127:0] p9;
	logic [131:0] tag9;
	logic [63:0]  yp9, u29, lmag9;
	logic         u2ov9, ovf9, islog9, lov9;

	vwf_mul #(.TAG_W(132)) u_mul_lam (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v8),
		.a(y4v8), .b(K_C193), .in_tag({yp8, u28, u2ov8, ovf8, islog8, lov8}),
		.out_v(v9), .p(p9), .out_tag(tag9)
	);

	assign {yp9, u29, u2ov9, ovf9, islog9, lov9} = tag9;
	assign lmag9 = p9[95:32];

	// Log branch: log2 of yPlus, 32 fraction bits
	logic         v10;
	logic [5:0]   msb10;
	logic [31:0]  frac10, e10;
	logic [131:0] tag10;
	logic [63:0]  l2_10, l2m10;
	logic         lneg10;

	vwf_log2 #(.TAG_W(132)) u_log2 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v9),
		.x(yp9), .in_tag({lmag9, u29, u2ov9, ovf9, islog9, lov9}),
		.out_v(v10), .msb(msb10), .frac(frac10), .out_tag(tag10)
	);

	// integer part is the msb position less the fraction bits, may go negative
	assign e10    = {26'b0, msb10} - 32'(FRAC_BITS);
	assign l2_10  = {e10, frac10};
	assign lneg10 = l2_10[63];
	assign l2m10  = lneg10 ? 64'(64'd0 - l2_10) : l2_10;

	// ln = log2 * ln 2
	logic         v11;
	logic [127:0] p11;
	logic [132:0] tag11;
	logic [63:0]  lnm11;

	vwf_mul #(.TAG_W(133)) u_mul_ln (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v10),
		.a(l2m10), .b(K_LN2), .in_tag({lneg10, tag10}),
		.out_v(v11), .p(p11), .out_tag(tag11)
	);

	assign lnm11 = p11[95:32];

	// (0.193/kappa) * ln, then the -0.94 offset
	logic         v12;
	logic [127:0] p12;
	logic [132:0] tag12;
	logic [63:0]  lmag12, u212, term12, c12, cmag12, mag12;
	logic         lneg12, u2ov12, ovf12, islog12, lov12, neg12, magz12;

	vwf_mul #(.TAG_W(133)) u_mul_term (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v11),
		.a(ratio_q), .b(lnm11), .in_tag(tag11),
		.out_v(v12), .p(p12), .out_tag(tag12)
	);

	assign {lneg12, lmag12, u212, u2ov12, ovf12, islog12, lov12} = tag12;
	assign term12 = p12[95:32];
	assign c12    = 64'((lneg12 ? 64'(64'd0 - term12) : term12) - K_B94);
	assign cmag12 = c12[63] ? 64'(64'd0 - c12) : c12;
	assign mag12  = islog12 ? cmag12 : lmag12;
	assign neg12  = islog12 && c12[63];
	assign magz12 = mag12 == '0;

	// value magnitude = coefficient * uTau^2
	logic         v13;
	logic [127:0] p13;
	logic [5:0]   tag13;
	logic         islog13, neg13, magz13, u2ov13, ovf13, lov13;
	logic [63:0]  rlo13;
	logic         rhi13;

	vwf_mul #(.TAG_W(6)) u_mul_val (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v12),
		.a(mag12), .b(u212), .in_tag({islog12, neg12, magz12, u2ov12, ovf12, lov12}),
		.out_v(v13), .p(p13), .out_tag(tag13)
	);

	assign {islog13, neg13, magz13, u2ov13, ovf13, lov13} = tag13;
	assign rlo13 = islog13 ? p13[95:32] : p13[FRAC_BITS +: 64];
	assign rhi13 = islog13 ? (p13[127:96] != '0) : ((p13 >> (64 + FRAC_BITS)) != '0);

	// Saturation and sign
	logic [63:0] val_d;
	logic        sat_d;

	always_comb begin
		val_d = rlo13;
		sat_d = 1'b0;
		if (ovf13 || (!islog13 && lov13)) begin
			// zero viscosity, yPlus overflow or yPlus power overflow
			val_d = MAXP;
			sat_d = 1'b1;
		end else if (magz13) begin
			val_d = '0;
		end else if (neg13) begin
			if (u2ov13 || rhi13 || rlo13 > 64'(MAXP + 64'd1)) begin
				val_d = MINN;
				sat_d = 1'b1;
			end else begin
				val_d = 64'(64'd0 - rlo13);
			end
		end else if (u2ov13 || rhi13 || rlo13 > MAXP) begin
			val_d = MAXP;
			sat_d = 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v13;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v2_value  <= val_d;
			saturated <= sat_d;
		end
	end

endmodule

// ===== dv/vwf_checker.sv =====
// Checker for the v2 wall-function block: tracks registers, predicts each face and compares.
`timescale 1ns / 1ps

module vwf_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [vwf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [63:0]                   wall_distance,
	input  logic [63:0]                   viscosity,
	input  logic [63:0]                   density,
	input  logic [63:0]                   turb_energy,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic signed [63:0]            v2_value,
	input  logic                          saturated,
	output int                            errors,
	output int                            outstanding
);
	import vwf_pkg::*;

	localparam int FB = 40;
	localparam logic [63:0] MAXP = 64'h7fff_ffff_ffff_ffff;

	typedef struct packed {
		logic [63:0] value;
		logic        sat;
	} wall_v2_t;

	logic [31:0] cmu_r4, kap, yp_lam;
	wall_v2_t    v2_due[$];

	function automatic logic [127:0] mul(logic [63:0] a, logic [63:0] b);
		return {64'd0, a} * {64'd0, b};
	endfunction

	function automatic logic [63:0] root_q(logic [127:0] x);
		logic [63:0] res, c;
		res = '0;
		for (int b = 63; b >= 0; b--) begin
			c = res | (64'd1 << b);
			if (mul(c, c) <= x)
				res = c;
		end
		return res;
	endfunction

	// log2 with 32 fraction bits, less the fraction width
	function automatic logic signed [63:0] log2_q32(logic [63:0] x);
		int          p;
		logic [63:0] m, frac;
		logic [127:0] sq;
		if (x == 0)
			x = 1;
		p = 63;
		while (!x[p])
			p--;
		m = x << (63 - p);
		frac = '0;
		for (int i = 0; i < 32; i++) begin
			sq = mul(m, m);
			frac = frac << 1;
			if (sq[127]) begin
				frac[0] = 1'b1;
				m = sq[127:64];
			end else begin
				m = sq[126:63];
			end
		end
		return (64'(signed'(p - FB)) << 32) + frac;
	endfunction

	function automatic wall_v2_t wall_v2(logic [63:0] y, logic [63:0] mu, logic [63:0] rho,
			logic [63:0] k);
		wall_v2_t             o;
		logic [63:0]          sqrtk, utau, yp, mag, u2, l2m, lnm, ratio, term, kd;
		logic [127:0]         t, n, u2w, r, y2, y4;
		logic signed [63:0]   l2, c;
		logic                 neg, u2over, lneg;
		o.value = MAXP;
		o.sat = 1'b1;
		if (mu == 0)
			return o;
		sqrtk = root_q({64'd0, k} << FB);
		utau = 64'(mul({32'd0, cmu_r4}, sqrtk) >> 24);
		t = mul(utau, y) >> FB;
		if (t[127:64] != 0)
			return o;
		n = mul(t[63:0], rho);
		if (n[127:64] >= mu)
			return o;
		yp = 64'(n / {64'd0, mu});
		u2w = mul(utau, utau) >> FB;
		u2over = |u2w[127:64];
		u2 = u2w[63:0];
		if (({64'd0, yp} << 24) > ({96'd0, yp_lam} << FB)) begin
			// log law
			l2 = log2_q32(yp);
			lneg = l2 < 0;
			l2m = lneg ? -l2 : l2;
			lnm = 64'(mul(l2m, K_LN2) >> 32);
			kd = (kap == 0) ? 64'd1 : {32'd0, kap};
			ratio = RATIO_NUM / kd;
			term = 64'(mul(ratio, lnm) >> 32);
			c = (lneg ? -signed'(term) : signed'(term)) - signed'(K_B94);
			neg = c < 0;
			mag = neg ? -c : c;
			r = mul(mag, u2) >> 32;
		end else begin
			// laminar
			y2 = mul(yp, yp) >> FB;
			if (y2[127:64] != 0)
				return o;
			y4 = mul(y2[63:0], y2[63:0]) >> FB;
			if (y4[127:64] != 0)
				return o;
			mag = 64'(mul(y4[63:0], K_C193) >> 32);
			neg = 1'b0;
			r = mul(mag, u2) >> FB;
		end
		if (mag == 0) begin
			o.value = '0;
			o.sat = 1'b0;
		end else if (neg) begin
			if (u2over || r[127:64] != 0 || r[63:0] > MAXP + 64'd1) begin
				o.value = ~MAXP;
			end else begin
				o.value = -r[63:0];
				o.sat = 1'b0;
			end
		end else if (!(u2over || r[127:64] != 0 || r[63:0] > MAXP)) begin
			o.value = r[63:0];
			o.sat = 1'b0;
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wall_v2_t due;
		int       miss;
		if (!arst_n) begin
			cmu_r4 <= CMU_ROOT4_RST;
			kap <= KAPPA_RST;
			yp_lam <= YPLUS_LAM_RST;
			v2_due.delete();
			errors <= 0;
			outstanding <= 0;
		end else begin
			miss = 0;
			if (out_valid && out_ready) begin
				if (v2_due.size() == 0) begin
					$error("result item with nothing expected: v2_value %h", v2_value);
					miss++;
				end else begin
					due = v2_due.pop_front();
					if (v2_value !== due.value) begin
						$error("v2_value: expected %h, got %h", due.value, v2_value);
						miss++;
					end
					if (saturated !== due.sat) begin
						$error("saturated: expected %b, got %b", due.sat, saturated);
						miss++;
					end
				end
			end
			errors <= errors + miss;
			if (in_valid && in_ready)
				v2_due.push_back(wall_v2(wall_distance, viscosity, density, turb_energy));
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_CMU_ROOT4: cmu_r4 <= cfg_data;
					CFG_KAPPA:     kap <= cfg_data;
					CFG_YPLUS_LAM: yp_lam <= cfg_data;
					default: ;
				endcase
			end
			outstanding <= v2_due.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the v2 wall-function block: stimulus, register phases and verdict.
`timescale 1ns / 1ps

module tb;
	import vwf_pkg::*;

	localparam int PHASE_FACES = 378;
	localparam int STALL_LIMIT = 5000;   // cycles with no item moving
	localparam int HOLD_CYCLES = 600;    // long receiver hold-off

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	logic                 in_valid, in_ready;
	logic [63:0]          wall_distance, viscosity, density, turb_energy;
	logic                 out_valid, out_ready;
	logic signed [63:0]   v2_value;
	logic                 saturated;
	int                   errors, outstanding;
	int                   faces_sent;
	bit                   quiet;      // no idling on either side
	bit                   hold_req;   // asks the receiver for a long hold-off

	v2_wall_function_value_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.wall_distance(wall_distance), .viscosity(viscosity),
		.density(density), .turb_energy(turb_energy),
		.out_valid(out_valid), .out_ready(out_ready),
		.v2_value(v2_value), .saturated(saturated)
	);

	vwf_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.wall_distance(wall_distance), .viscosity(viscosity),
		.density(density), .turb_energy(turb_energy),
		.out_valid(out_valid), .out_ready(out_ready),
		.v2_value(v2_value), .saturated(saturated),
		.errors(errors), .outstanding(outstanding)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Register write, one cycle of write enable; called at a falling edge
	task automatic set_reg(cfg_idx_t idx, logic [31:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offer one face and hold it until taken; valid stays up for a following item unless a random idle gap is drawn
	task automatic push_face(logic [63:0] y, logic [63:0] mu, logic [63:0] rho,
			logic [63:0] k);
		in_valid <= 1'b1;
		wall_distance <= y;
		viscosity <= mu;
		density <= rho;
		turb_energy <= k;
		do
			@(posedge clk);
		while (!in_ready);
		faces_sent++;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
	endtask

	// Full 64-bit noise shifted down by a random amount, so every bit toggles
	function automatic logic [63:0] any_q();
		return {$urandom, $urandom} >> $urandom_range(0, 63);
	endfunction

	// Value near 2^e in Q24.40, e counted in raw bits
	function automatic logic [63:0] near_pow(int lo_e, int hi_e);
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v >> (64 - $urandom_range(lo_e, hi_e));
	endfunction

	// Mostly plausible wall faces; a share of raw noise and zero viscosity
	task automatic random_faces(int n);
		logic [63:0] y, mu, rho, k;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					y = any_q();
					mu = any_q();
					rho = any_q();
					k = any_q();
				end
				2: begin
					y = any_q();
					mu = '0;
					rho = any_q();
					k = any_q();
				end
				default: begin
					// y 2^-17..2^1, mu 2^-20..2^-9, rho 2^-3..2^4, k 2^-13..2^7
					y = near_pow(23, 41);
					mu = near_pow(20, 31);
					rho = near_pow(37, 44);
					k = near_pow(27, 47);
				end
			endcase
			push_face(y, mu, rho, k);
		end
	endtask

	// Block idle: every expected result back before a register write
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		wait (outstanding == 0 && !out_valid);
		@(negedge clk);
	endtask

	// Receiver: random ready with bursts of back-pressure, and one long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(negedge clk);
			end
		end
	end

	// Watchdog: counts cycles with no item accepted on either channel
	initial begin
		int idle_cnt;
		idle_cnt = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cnt = 0;
			else
				idle_cnt++;
			if (idle_cnt >= STALL_LIMIT) begin
				$display("timeout: %0d cycles with no item moving", STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		wall_distance = '0;
		viscosity = '0;
		density = '0;
		turb_energy = '0;
		faces_sent = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed faces on reset constants
		push_face(64'd1 << 30, 64'd0, 64'd1 << 40, 64'd1 << 40);            // zero viscosity
		push_face('0, 64'd1, '0, '0);                                          // all zero but viscosity
		push_face('1, '1, '1, '1);                                             // all at max
		push_face('1, 64'd1, '1, '1);                                          // t overflows
		push_face(64'd1 << 40, 64'd1, '1, 64'd1 << 40);                        // yPlus overflows
		push_face(64'd1 << 30, 64'd19791209, 64'd1 << 40, '0);                 // k zero
		push_face(64'd1 << 30, 64'd19791209, 64'd1 << 40, 64'd1 << 40);        // log law
		push_face(64'd1 << 26, 64'd19791209, 64'd1 << 40, 64'd1 << 40);        // laminar
		push_face(64'd1 << 34, 64'd19791209, 64'd1 << 40, 64'd1 << 40);        // far log law
		push_face(64'd1 << 20, 64'd1 << 40, 64'd1 << 40, 64'd1 << 40);         // tiny yPlus
		push_face(64'd1 << 40, 64'd1, 64'd1 << 40, '1);                        // large k, yPlus overflows
		push_face(64'd1, '1, 64'd1, 64'd1);                                    // smallest nonzero, viscosity at max
		random_faces(PHASE_FACES);
		drain();

		// Extremes: biggest cmu, smallest kappa, crossover at zero
		set_reg(CFG_CMU_ROOT4, '1);
		set_reg(CFG_KAPPA, 32'd1);
		set_reg(CFG_YPLUS_LAM, '0);
		random_faces(PHASE_FACES);
		drain();

		// Other extremes: cmu zero, biggest kappa, crossover at max; all laminar until cmu is restored
		set_reg(CFG_CMU_ROOT4, '0);
		set_reg(CFG_KAPPA, '1);
		set_reg(CFG_YPLUS_LAM, '1);
		random_faces(PHASE_FACES / 2);
		drain();
		set_reg(CFG_CMU_ROOT4, CMU_ROOT4_RST);
		random_faces(PHASE_FACES / 2);
		drain();

		// Random registers, with one long receiver hold-off so the pipe fills
		set_reg(CFG_CMU_ROOT4, $urandom);
		set_reg(CFG_KAPPA, $urandom_range(1, 32'hffff_ffff));
		set_reg(CFG_YPLUS_LAM, $urandom_range(0, 32'h1000_0000));
		hold_req = 1'b1;
		random_faces(PHASE_FACES);
		drain();

		// Back to usual constants, both sides flat out
		set_reg(CFG_CMU_ROOT4, CMU_ROOT4_RST);
		set_reg(CFG_KAPPA, KAPPA_RST);
		set_reg(CFG_YPLUS_LAM, YPLUS_LAM_RST);
		quiet = 1'b1;
		random_faces(PHASE_FACES);
		in_valid <= 1'b0;

		wait (outstanding == 0);
		repeat (300) @(negedge clk);

		$display("covered %0d wall faces over six register settings, extremes included,",
			faces_sent);
		$display("with random back-pressure, a long result hold-off and a full-rate tail");
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
